FILE: hw/rtl/rstu_pkg.sv
package rstu_pkg;

    localparam int RELATIONS = 8;
    localparam int MEASURES  = 16;
    localparam int ENTRIES   = RELATIONS * MEASURES;
    localparam int ENTRY_W   = $clog2(ENTRIES);

    localparam int REL_W  = 3;
    localparam int MI_W   = 4;
    localparam int X_W    = 32;
    localparam int CNT_W  = 16;
    localparam int STD_W  = 31;
    localparam int CFG_W  = 4;
    localparam int VAR_W  = 64;
    localparam int ROW_W  = CNT_W + X_W + 2 * VAR_W;
    localparam int DEN_W  = CNT_W + 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef struct packed {
        logic in_take;
        logic rd;
        logic load;
        logic mul1;
        logic mean_go;
        logic mean_fix;
        logic mul2;
        logic vdiv_go;
        logic take_a;
        logic pdiv_go;
        logic take_v;
        logic sqrt_go;
        logic write;
        logic out_load;
        logic out_bad;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } t_stat;

endpackage

FILE: hw/rtl/running_stats_table_update.sv
// The shared one-bit-per-cycle divider runs three 64-step divisions per sample, and the
// square root takes 32 steps, so a new sample is accepted only once the last one, valid or rejected, is finished.
// A finished result waits in the output register while the next transaction is accepted.
// Synchronous active-low reset zeroes every table entry at once through per-entry valid
// bits and sets relation_count to 8.
module running_stats_table_update (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rstu_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [rstu_pkg::REL_W-1:0]       i_relation,
    input  logic [rstu_pkg::MI_W-1:0]        i_measure_index,
    input  logic signed [rstu_pkg::X_W-1:0]  i_sample,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_bad_relation,
    output logic [rstu_pkg::CNT_W-1:0]       o_count,
    output logic signed [rstu_pkg::X_W-1:0]  o_mean,
    output logic [rstu_pkg::STD_W-1:0]       o_std_dev
);

    rstu_pkg::t_cmd  cmd;
    rstu_pkg::t_stat stat;
    logic            ready;

    rstu_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(ready),
        .o_cmd  (cmd),
        .i_stat (stat)
    );

    rstu_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_relation     (i_relation),
        .i_measure_index(i_measure_index),
        .i_sample       (i_sample),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_bad_relation (o_bad_relation),
        .o_count        (o_count),
        .o_mean         (o_mean),
        .o_std_dev      (o_std_dev)
    );

    assign o_stall = !ready;

endmodule

FILE: hw/rtl/rstu_ram.sv
module rstu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/rstu_div.sv
module rstu_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [63:0]               i_dividend,
    input  logic [rstu_pkg::DEN_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [63:0]               o_quot,
    output logic [rstu_pkg::DEN_W-1:0] o_rem
);

    logic [63:0]               r_q;
    logic [rstu_pkg::DEN_W-1:0] r_r;
    logic [rstu_pkg::DEN_W-1:0] r_d;
    logic [6:0]                r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [rstu_pkg::DEN_W:0]   t;
    logic                      ge;

    assign t  = {r_r, r_q[63]};
    assign ge = t >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 7'd64;
            r_q    <= i_dividend;
            r_r    <= '0;
            r_d    <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[62:0], ge};
            if (ge) begin
                r_r <= rstu_pkg::DEN_W'(t - {1'b0, r_d});
            end else begin
                r_r <= t[rstu_pkg::DEN_W-1:0];
            end
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

FILE: hw/rtl/rstu_sqrt.sv
module rstu_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_val;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [35:0] t;
    logic [35:0] trial;
    logic        ge;

    assign t     = {r_rem, r_val[63:62]};
    assign trial = {2'b00, r_root, 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 6'd32;
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[61:0], 2'b00};
            if (ge) begin
                r_rem  <= 34'(t - trial);
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= t[33:0];
                r_root <= {r_root[30:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: hw/rtl/rstu_datapath.sv
module rstu_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rstu_pkg::t_cmd                   i_cmd,
    output rstu_pkg::t_stat                  o_stat,
    input  logic                             i_cfg_we,
    input  logic [rstu_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic [rstu_pkg::REL_W-1:0]       i_relation,
    input  logic [rstu_pkg::MI_W-1:0]        i_measure_index,
    input  logic signed [rstu_pkg::X_W-1:0]  i_sample,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic                             o_bad_relation,
    output logic [rstu_pkg::CNT_W-1:0]       o_count,
    output logic signed [rstu_pkg::X_W-1:0]  o_mean,
    output logic [rstu_pkg::STD_W-1:0]       o_std_dev
);

    logic [rstu_pkg::CFG_W-1:0]      r_rel_count;
    logic [rstu_pkg::REL_W-1:0]      r_rel;
    logic [rstu_pkg::MI_W-1:0]       r_mi;
    logic signed [31:0]              r_x;
    logic [rstu_pkg::ENTRIES-1:0]    r_ent_vld;
    logic                            r_hit;
    logic [15:0]                     r_n;
    logic signed [31:0]              r_m;
    logic [63:0]                     r_ss;
    logic [63:0]                     r_v;
    logic signed [48:0]              r_nm;
    logic [63:0]                     r_xx;
    logic [16:0]                     r_d;
    logic                            r_neg;
    logic signed [31:0]              r_mn;
    logic [63:0]                     r_p;
    logic [63:0]                     r_a;
    logic [63:0]                     r_vn;
    logic                            r_o_valid;
    logic                            r_o_bad;
    logic [15:0]                     r_o_count;
    logic signed [31:0]              r_o_mean;
    logic [30:0]                     r_o_std;

    logic [rstu_pkg::ENTRY_W-1:0]    idx;
    logic [rstu_pkg::ROW_W-1:0]      rdata;
    logic [rstu_pkg::ROW_W-1:0]      wdata;
    logic [31:0]                     x_mag;
    logic signed [51:0]              num_c;
    logic [51:0]                     num_mag;
    logic                            div_start;
    logic [63:0]                     div_dividend;
    logic [rstu_pkg::DEN_W-1:0]      div_divisor;
    logic                            div_done;
    logic [63:0]                     div_q;
    logic [rstu_pkg::DEN_W-1:0]      div_r;
    logic                            sqrt_done;
    logic [31:0]                     sqrt_root;
    logic [32:0]                     mn_mag;
    logic [32:0]                     mn_c;
    logic signed [32:0]              dm;
    logic signed [32:0]              dn;
    logic [31:0]                     dm_mag;
    logic [31:0]                     dn_mag;
    logic [64:0]                     vsum;
    logic [64:0]                     ssum;
    logic [15:0]                     cnt_new;
    logic [63:0]                     ss_new;

    assign idx = rstu_pkg::ENTRY_W'(int'(r_rel) * rstu_pkg::MEASURES + int'(r_mi));

    assign o_stat.bad = ({1'b0, r_rel} >= r_rel_count)
                     || (int'(r_rel) >= rstu_pkg::RELATIONS)
                     || (int'(r_mi) >= rstu_pkg::MEASURES);
    assign o_stat.div_done  = div_done;
    assign o_stat.sqrt_done = sqrt_done;
    assign o_stat.out_free  = !r_o_valid || !i_stall;

    assign x_mag   = r_x[31] ? 32'(-r_x) : 32'(r_x);
    assign num_c   = ((52'(r_nm) + 52'(r_x)) <<< 1) + $signed({35'd0, r_d});
    assign num_mag = num_c[51] ? 52'(-num_c) : 52'(num_c);

    assign div_start = i_cmd.mean_go || i_cmd.vdiv_go || i_cmd.pdiv_go;

    always_comb begin
        if (i_cmd.mean_go) begin
            div_dividend = {12'd0, num_mag};
            div_divisor  = {r_d, 1'b0};
        end else if (i_cmd.vdiv_go) begin
            div_dividend = r_v;
            div_divisor  = {1'b0, r_d};
        end else begin
            div_dividend = r_p;
            div_divisor  = {1'b0, r_d};
        end
    end

    assign mn_mag = {1'b0, div_q[31:0]} + 33'(r_neg && (div_r != '0));
    assign mn_c   = r_neg ? 33'(-mn_mag) : mn_mag;

    assign dm     = 33'(r_x) - 33'(r_m);
    assign dn     = 33'(r_x) - 33'(r_mn);
    assign dm_mag = dm[32] ? 32'(-dm) : dm[31:0];
    assign dn_mag = dn[32] ? 32'(-dn) : dn[31:0];

    assign vsum    = {1'b0, r_a} + {1'b0, div_q};
    assign ssum    = {1'b0, r_ss} + {1'b0, r_xx};
    assign ss_new  = ssum[64] ? '1 : ssum[63:0];
    assign cnt_new = (r_n == '1) ? r_n : r_n + 16'd1;
    assign wdata   = {cnt_new, r_mn, ss_new, r_vn};

    rstu_ram #(
        .WIDTH(rstu_pkg::ROW_W),
        .DEPTH(rstu_pkg::ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.write),
        .i_waddr(idx),
        .i_wdata(wdata),
        .i_re   (i_cmd.rd),
        .i_raddr(idx),
        .o_rdata(rdata)
    );

    rstu_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dividend),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quot    (div_q),
        .o_rem     (div_r)
    );

    rstu_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.sqrt_go),
        .i_value(r_vn),
        .o_done (sqrt_done),
        .o_root (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel_count <= rstu_pkg::CFG_RESET;
            r_ent_vld   <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rel_count <= i_cfg_wdata;
            end
            if (i_cmd.write) begin
                r_ent_vld[idx] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_rel <= i_relation;
            r_mi  <= i_measure_index;
            r_x   <= i_sample;
        end
        if (i_cmd.rd) begin
            r_hit <= r_ent_vld[idx];
        end
        if (i_cmd.load) begin
            r_n  <= r_hit ? rdata[rstu_pkg::ROW_W-1 -: 16] : '0;
            r_m  <= r_hit ? $signed(rdata[159:128]) : '0;
            r_ss <= r_hit ? rdata[127:64] : '0;
            r_v  <= r_hit ? rdata[63:0] : '0;
        end
        if (i_cmd.mul1) begin
            r_nm <= $signed({1'b0, r_n}) * r_m;
            r_xx <= x_mag * x_mag;
            r_d  <= {1'b0, r_n} + 17'd1;
        end
        if (i_cmd.mean_go) begin
            r_neg <= num_c[51];
        end
        if (i_cmd.mean_fix) begin
            r_mn <= $signed(mn_c[31:0]);
        end
        if (i_cmd.mul2) begin
            r_p <= dm_mag * dn_mag;
        end
        if (i_cmd.take_a) begin
            r_a <= r_v - div_q;
        end
        if (i_cmd.take_v) begin
            r_vn <= vsum[64] ? '1 : vsum[63:0];
        end
        if (i_cmd.out_load) begin
            r_o_bad   <= i_cmd.out_bad;
            r_o_count <= i_cmd.out_bad ? '0 : cnt_new;
            r_o_mean  <= i_cmd.out_bad ? '0 : r_mn;
            if (i_cmd.out_bad) begin
                r_o_std <= '0;
            end else if (sqrt_root[31]) begin
                r_o_std <= '1;
            end else begin
                r_o_std <= sqrt_root[30:0];
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_bad_relation = r_o_bad;
    assign o_count        = r_o_count;
    assign o_mean         = r_o_mean;
    assign o_std_dev      = r_o_std;

endmodule

FILE: hw/rtl/rstu_ctrl.sv
module rstu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output rstu_pkg::t_cmd  o_cmd,
    input  rstu_pkg::t_stat i_stat
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_LOAD,
        S_MUL1,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_MEAN_FIX,
        S_MUL2,
        S_VDIV_GO,
        S_VDIV_WAIT,
        S_PDIV_GO,
        S_PDIV_WAIT,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_WRITE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_bad;
    logic   n_bad;

    always_comb begin
        n_state = r_state;
        n_bad   = r_bad;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_take = i_valid;
                if (i_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_bad = i_stat.bad;
                if (i_stat.bad) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MEAN_GO;
            end
            S_MEAN_GO: begin
                o_cmd.mean_go = 1'b1;
                n_state       = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_MEAN_FIX;
                end
            end
            S_MEAN_FIX: begin
                o_cmd.mean_fix = 1'b1;
                n_state        = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_VDIV_GO;
            end
            S_VDIV_GO: begin
                o_cmd.vdiv_go = 1'b1;
                n_state       = S_VDIV_WAIT;
            end
            S_VDIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.take_a = 1'b1;
                    n_state      = S_PDIV_GO;
                end
            end
            S_PDIV_GO: begin
                o_cmd.pdiv_go = 1'b1;
                n_state       = S_PDIV_WAIT;
            end
            S_PDIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.take_v = 1'b1;
                    n_state      = S_SQRT_GO;
                end
            end
            S_SQRT_GO: begin
                o_cmd.sqrt_go = 1'b1;
                n_state       = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (i_stat.sqrt_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_bad  = r_bad;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bad   <= n_bad;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule
